/* sv/rts_pkg.sv */
// Shared types and constants of the RTT tracking server selector.
package rts_pkg;

	localparam int MASK_W = 16;
	localparam int CNT_W = 5;
	localparam logic [15:0] MS_PER_SEC = 16'd1000;
	localparam logic [5:0] DEFAULT_TIMEOUT = 6'd4;

	typedef enum logic [1:0] {
		REQ_RTT = 2'd0,
		REQ_TIMEOUT = 2'd1,
		REQ_CHOOSE = 2'd2,
		REQ_SET_AVG = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		CFG_SERVER_COUNT = 3'd0,
		CFG_VALID_ADDR = 3'd1,
		CFG_TESTED = 3'd2,
		CFG_HIJACKED = 3'd3,
		CFG_EDNS = 3'd4,
		CFG_TIMEOUT = 3'd5
	} cfg_idx_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SUM,
		ST_DIV_AVG,
		ST_SCAN,
		ST_DIV_PICK,
		ST_PICK,
		ST_OUT
	} state_t;

endpackage

/* sv/rts_hist_mem.sv */
// Sample history memory with one write port and a registered read port.
module rts_hist_mem #(
	parameter int DEPTH = 160,
	parameter int AW = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);

	logic [15:0] mem [DEPTH];
	logic [15:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* sv/rts_avg_mem.sv */
// Per-server average memory; an entry never written reads as zero.
module rts_avg_mem #(
	parameter int DEPTH = 16,
	parameter int AW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [15:0]   rdata
);

	logic [15:0]    mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	logic [15:0]    rdata_s1;
	logic           vld_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			vld_s1 <= 1'b0;
		end else begin
			if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (re) begin
				vld_s1 <= valid_q[raddr];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_s1 <= mem[raddr];
		end
	end

	assign rdata = vld_s1 ? rdata_s1 : 16'd0;

endmodule

/* sv/rts_div.sv */
// Restoring divider that retires one quotient bit per cycle.
module rts_div #(
	parameter int DW = 20,
	parameter int VW = 5
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [DW-1:0] dividend,
	input  logic [VW-1:0] divisor,
	output logic          done,
	output logic [DW-1:0] quot,
	output logic [VW-1:0] rem
);

	localparam int CW = $clog2(DW + 1);

	logic [DW-1:0] quo_q;
	logic [VW-1:0] rem_q;
	logic [VW-1:0] dvs_q;
	logic [CW-1:0] cnt_q;
	logic          busy_q;
	logic          done_q;
	logic [VW:0]   trial;
	logic [VW:0]   diff;

	assign trial = {rem_q, quo_q[DW-1]};
	assign diff = trial - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= CW'(DW);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			if (!diff[VW]) begin
				rem_q <= diff[VW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b1};
			end else begin
				rem_q <= trial[VW-1:0];
				quo_q <= {quo_q[DW-2:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quot = quo_q;
	assign rem = rem_q;

endmodule

/* sv/rtt_tracking_server_selector.sv */
// Top level: request sequencer over the history and average memories.
// A probe set-average or an invalid server index loads the result register on acceptance.
// A sample sums the n filled entries of its server's history and divides the sum by n.
// A choose request scans min(NUM_SERVERS,16) averages, one per cycle from the average
// memory, then, with no positive average, a divider pass and a second scan.
// One request at a time; reset clears ring pointers, fill counts and average valid bits.
module rtt_tracking_server_selector
	import rts_pkg::*;
#(
	parameter int NUM_SERVERS = 16,
	parameter int HISTORY_DEPTH = 10
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  req_type,
	input  logic [3:0]  server_index,
	input  logic [15:0] rtt_sample,
	input  logic [15:0] exclude_mask,
	input  logic [15:0] random_value,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [3:0]  chosen_server,
	output logic        server_found,
	output logic [15:0] average_rtt,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [15:0] cfg_data
);

	localparam int IDX_W = $clog2(NUM_SERVERS);
	localparam int HIST_N = NUM_SERVERS * HISTORY_DEPTH;
	localparam int HIST_AW = $clog2(HIST_N);
	localparam int SLOT_W = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
	localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
	localparam int SUM_W = 16 + FILL_W;
	localparam int DIV_W = (SUM_W > 16) ? SUM_W : 16;
	localparam int DVS_W = (FILL_W > CNT_W) ? FILL_W : CNT_W;
	localparam int SCAN_N = (NUM_SERVERS < MASK_W) ? NUM_SERVERS : MASK_W;

	// Configuration registers.
	logic [4:0]  server_count_q;
	logic [15:0] valid_addr_q, tested_q, hijacked_q, edns_q;
	logic [5:0]  timeout_q;

	// Per-server ring control.
	logic [SLOT_W-1:0] next_slot_q [NUM_SERVERS];
	logic [FILL_W-1:0] fill_q [NUM_SERVERS];

	state_t state_q, state_d;

	logic [IDX_W-1:0]   idx_q;
	logic [HIST_AW-1:0] base_q;
	logic [FILL_W-1:0]  n_q, k_q;
	logic [SUM_W-1:0]   acc_q;
	logic               rd_s1;
	logic [4:0]         j_q, j_s1;
	logic [15:0]        elig_q;
	logic [CNT_W-1:0]   cnt_q;
	logic [CNT_W-1:0]   pick_q;
	logic               have_q;
	logic [3:0]         best_q;
	logic [15:0]        best_avg_q;
	logic [15:0]        rnd_q;

	logic [3:0]  res_chosen_q;
	logic        res_found_q;
	logic [15:0] res_avg_q;

	logic        out_valid_q;
	logic [3:0]  chosen_q;
	logic        found_q;
	logic [15:0] avg_q;

	// Request decode.
	logic              accept;
	logic              idx_ok;
	logic [IDX_W-1:0]  idx_in;
	logic [15:0]       ms;
	logic [5:0]        tsec;
	logic [SLOT_W-1:0] slot;
	logic [FILL_W-1:0] fill_new;
	logic [HIST_AW-1:0] base_in;

	// Eligibility.
	logic [15:0]      elig_raw, elig_edns, elig;
	logic [CNT_W-1:0] elig_cnt;

	// Memory and divider hookup.
	logic               hist_we, hist_re;
	logic [HIST_AW-1:0] hist_waddr, hist_raddr;
	logic [15:0]        hist_rdata;
	logic               avg_we, avg_re;
	logic [IDX_W-1:0]   avg_waddr, avg_raddr;
	logic [15:0]        avg_wdata, avg_rdata;
	logic               div_start, div_done;
	logic [DIV_W-1:0]   div_dividend, div_quot;
	logic [DVS_W-1:0]   div_divisor, div_rem;

	logic sum_last, scan_last, out_load;

	assign accept = in_valid && !in_stall;
	assign in_stall = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;

	assign idx_ok = (32'(server_index) < NUM_SERVERS);
	assign idx_in = IDX_W'(server_index);
	assign tsec = (timeout_q == 6'd0) ? DEFAULT_TIMEOUT : timeout_q;
	assign ms = (req_type == REQ_TIMEOUT) ? 16'({10'd0, tsec} * MS_PER_SEC) : rtt_sample;
	assign slot = next_slot_q[idx_in];
	assign fill_new = (32'(fill_q[idx_in]) < HISTORY_DEPTH) ?
		fill_q[idx_in] + 1'b1 : fill_q[idx_in];
	assign base_in = HIST_AW'(32'(idx_in) * HISTORY_DEPTH);

	always_comb begin
		for (int i = 0; i < MASK_W; i++) begin
			elig_raw[i] = (i < SCAN_N) && (i < 32'(server_count_q)) && !exclude_mask[i]
				&& tested_q[i] && !hijacked_q[i] && valid_addr_q[i];
		end
		elig_edns = elig_raw & edns_q;
		elig = (elig_edns != 16'd0) ? elig_edns : elig_raw;
		elig_cnt = '0;
		for (int i = 0; i < MASK_W; i++) begin
			elig_cnt = elig_cnt + CNT_W'(elig[i]);
		end
	end

	assign hist_we = accept && idx_ok && (req_type == REQ_RTT || req_type == REQ_TIMEOUT);
	assign hist_waddr = base_in + HIST_AW'(slot);
	assign hist_re = (state_q == ST_SUM) && (k_q < n_q);
	assign hist_raddr = base_q + HIST_AW'(k_q);

	assign sum_last = (state_q == ST_SUM) && (k_q == n_q) && !rd_s1;
	assign scan_last = (state_q == ST_SCAN) && (32'(j_q) == SCAN_N) && !rd_s1;

	assign avg_re = (state_q == ST_SCAN) && (32'(j_q) < SCAN_N);
	assign avg_raddr = IDX_W'(j_q);
	always_comb begin
		avg_we = 1'b0;
		avg_waddr = idx_q;
		avg_wdata = div_quot[15:0];
		if (accept && idx_ok && req_type == REQ_SET_AVG) begin
			avg_we = 1'b1;
			avg_waddr = idx_in;
			avg_wdata = rtt_sample;
		end else if (state_q == ST_DIV_AVG && div_done) begin
			avg_we = 1'b1;
		end
	end

	assign div_start = sum_last || (scan_last && !have_q);
	assign div_dividend = sum_last ? DIV_W'(acc_q) : DIV_W'(rnd_q);
	assign div_divisor = sum_last ? DVS_W'(n_q) : DVS_W'(cnt_q);

	assign out_load = (state_q == ST_OUT) && (!out_valid_q || !out_stall);

	rts_hist_mem #(.DEPTH(HIST_N), .AW(HIST_AW)) u_hist (
		.clk(clk), .we(hist_we), .waddr(hist_waddr), .wdata(ms),
		.re(hist_re), .raddr(hist_raddr), .rdata(hist_rdata)
	);

	rts_avg_mem #(.DEPTH(NUM_SERVERS), .AW(IDX_W)) u_avg (
		.clk(clk), .arst_n(arst_n), .we(avg_we), .waddr(avg_waddr), .wdata(avg_wdata),
		.re(avg_re), .raddr(avg_raddr), .rdata(avg_rdata)
	);

	rts_div #(.DW(DIV_W), .VW(DVS_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(div_dividend),
		.divisor(div_divisor), .done(div_done), .quot(div_quot), .rem(div_rem)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (req_type == REQ_CHOOSE) begin
						state_d = (elig == 16'd0) ? ST_OUT : ST_SCAN;
					end else if (idx_ok && req_type != REQ_SET_AVG) begin
						state_d = ST_SUM;
					end else begin
						state_d = ST_OUT;
					end
				end
			end
			ST_SUM: if (sum_last) state_d = ST_DIV_AVG;
			ST_DIV_AVG: if (div_done) state_d = ST_OUT;
			ST_SCAN: begin
				if (scan_last) begin
					state_d = have_q ? ST_OUT : ST_DIV_PICK;
				end
			end
			ST_DIV_PICK: if (div_done) state_d = ST_PICK;
			ST_PICK: begin
				if (elig_q[j_q[3:0]] && pick_q == '0) begin
					state_d = ST_OUT;
				end
			end
			ST_OUT: if (out_load) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// Configuration, ring control and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			server_count_q <= '0;
			valid_addr_q <= '0;
			tested_q <= '0;
			hijacked_q <= '0;
			edns_q <= '0;
			timeout_q <= DEFAULT_TIMEOUT;
			for (int i = 0; i < NUM_SERVERS; i++) begin
				next_slot_q[i] <= '0;
				fill_q[i] <= '0;
			end
			out_valid_q <= 1'b0;
			rd_s1 <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_SERVER_COUNT: server_count_q <= cfg_data[4:0];
					CFG_VALID_ADDR: valid_addr_q <= cfg_data;
					CFG_TESTED: tested_q <= cfg_data;
					CFG_HIJACKED: hijacked_q <= cfg_data;
					CFG_EDNS: edns_q <= cfg_data;
					CFG_TIMEOUT: timeout_q <= cfg_data[5:0];
					default: ;
				endcase
			end
			if (hist_we) begin
				next_slot_q[idx_in] <= (32'(slot) + 1 >= HISTORY_DEPTH) ?
					'0 : slot + 1'b1;
				fill_q[idx_in] <= fill_new;
			end
			rd_s1 <= hist_re || avg_re;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Request datapath.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					idx_q <= idx_in;
					base_q <= base_in;
					n_q <= fill_new;
					k_q <= '0;
					acc_q <= '0;
					j_q <= '0;
					elig_q <= elig;
					cnt_q <= elig_cnt;
					have_q <= 1'b0;
					best_q <= '0;
					best_avg_q <= '0;
					rnd_q <= random_value;
					res_chosen_q <= (req_type == REQ_CHOOSE) ? 4'd0 : server_index;
					res_found_q <= (req_type != REQ_CHOOSE) && idx_ok;
					res_avg_q <= (req_type == REQ_SET_AVG && idx_ok) ? rtt_sample : 16'd0;
				end
			end
			ST_SUM: begin
				if (hist_re) begin
					k_q <= k_q + 1'b1;
				end
				if (rd_s1) begin
					acc_q <= acc_q + SUM_W'(hist_rdata);
				end
			end
			ST_DIV_AVG: begin
				if (div_done) begin
					res_avg_q <= div_quot[15:0];
				end
			end
			ST_SCAN: begin
				if (avg_re) begin
					j_q <= j_q + 1'b1;
				end
				j_s1 <= j_q;
				if (rd_s1 && elig_q[j_s1[3:0]] && avg_rdata != 16'd0
						&& (!have_q || avg_rdata < best_avg_q)) begin
					have_q <= 1'b1;
					best_q <= j_s1[3:0];
					best_avg_q <= avg_rdata;
				end
				if (scan_last && have_q) begin
					res_chosen_q <= best_q;
					res_found_q <= 1'b1;
					res_avg_q <= best_avg_q;
				end
			end
			ST_DIV_PICK: begin
				if (div_done) begin
					pick_q <= CNT_W'(div_rem);
					j_q <= '0;
				end
			end
			ST_PICK: begin
				if (elig_q[j_q[3:0]]) begin
					if (pick_q == '0) begin
						res_chosen_q <= j_q[3:0];
						res_found_q <= 1'b1;
						res_avg_q <= 16'd0;
					end else begin
						pick_q <= pick_q - 1'b1;
					end
				end
				j_q <= j_q + 1'b1;
			end
			ST_OUT: begin
				if (out_load) begin
					chosen_q <= res_chosen_q;
					found_q <= res_found_q;
					avg_q <= res_avg_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign chosen_server = chosen_q;
	assign server_found = found_q;
	assign average_rtt = avg_q;

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> in_stall)
		else $error("request accepted while a request was in flight");

	a_not_found_zero_avg: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !server_found) |-> (average_rtt == 16'd0))
		else $error("nonzero average reported without a server");

	a_sum_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SUM) |-> (k_q <= n_q))
		else $error("history read beyond the filled entries");

endmodule
